>>> rtl/stepper_positioner_with_homing_top_assert.svh
// Assertion macros shared by the RTL.
// ASSERT_CLK   : property holds at every rising edge out of reset.
// ASSERT_NEVER : condition is never true at a rising edge out of reset.
`ifndef STEPPER_POSITIONER_WITH_HOMING_TOP_ASSERT_SVH
`define STEPPER_POSITIONER_WITH_HOMING_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: %m");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen: %m");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/spwh_pkg.sv
package spwh_pkg;

	localparam int FULL_TRAVEL_STEPS = 10240;
	localparam int PCT_MAX           = 100;
	localparam int POS_W             = $clog2(FULL_TRAVEL_STEPS + 1);
	localparam int PCT_W             = $clog2(PCT_MAX + 1);

	// action codes
	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_TARGET = 2'd1;
	localparam logic [1:0] ACT_HOME   = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_HOMING = 2'd1,
		MODE_MOVING = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]        action;
		logic signed [7:0] percent;
		logic              at_top;
		logic              slot_free;
	} item_t;

	typedef struct packed {
		logic             step_pulse;
		logic             dir_down;
		logic             take_slot;
		logic             give_slot;
		mode_t            mode_now;
		logic [PCT_W-1:0] shown_percent;
	} result_t;

	typedef logic [POS_W-1:0] steps_lut_t [0:PCT_MAX];
	typedef logic [PCT_W-1:0] shown_lut_t [0:PCT_MAX];

	// percent -> steps, rounded down
	function automatic steps_lut_t build_steps();
		steps_lut_t t;
		for (int i = 0; i <= PCT_MAX; i++) begin
			t[i] = POS_W'(FULL_TRAVEL_STEPS * i / PCT_MAX);
		end
		return t;
	endfunction

	// steps of that percent -> percent again, rounded down
	function automatic shown_lut_t build_shown();
		shown_lut_t t;
		for (int i = 0; i <= PCT_MAX; i++) begin
			t[i] = PCT_W'((FULL_TRAVEL_STEPS * i / PCT_MAX) * PCT_MAX / FULL_TRAVEL_STEPS);
		end
		return t;
	endfunction

	localparam steps_lut_t STEPS_LUT = build_steps();
	localparam shown_lut_t SHOWN_LUT = build_shown();

endpackage

>>> rtl/spwh_core.sv
`include "stepper_positioner_with_homing_top_assert.svh"

module spwh_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  spwh_pkg::item_t   item,
	output spwh_pkg::result_t res
);
	import spwh_pkg::*;

	mode_t            mode_q, mode_d;
	logic [POS_W-1:0] position_q, position_d;
	logic [POS_W-1:0] target_q, target_d;
	logic [POS_W-1:0] wtarget_q, wtarget_d;
	logic             home_q, home_d;
	logic             dir_q, dir_d;
	logic [PCT_W-1:0] shown_q, shown_d;
	logic [PCT_W-1:0] pct_idx;
	logic             step, take, give;

	// clamp to 0..100
	always_comb begin
		if (item.percent[7]) begin
			pct_idx = '0;
		end else if (item.percent > 8'sd100) begin
			pct_idx = PCT_W'(PCT_MAX);
		end else begin
			pct_idx = item.percent[PCT_W-1:0];
		end
	end

	always_comb begin
		mode_d     = mode_q;
		position_d = position_q;
		target_d   = target_q;
		wtarget_d  = wtarget_q;
		home_d     = home_q;
		dir_d      = dir_q;
		shown_d    = shown_q;
		step       = 1'b0;
		take       = 1'b0;
		give       = 1'b0;
		unique case (item.action)
			ACT_TARGET: begin
				target_d = STEPS_LUT[pct_idx];
				shown_d  = SHOWN_LUT[pct_idx];
			end
			ACT_HOME: begin
				home_d = 1'b1;
			end
			ACT_TICK: begin
				unique case (mode_q)
					MODE_HOMING: begin
						if (item.at_top) begin
							mode_d     = MODE_IDLE;
							position_d = '0;
							home_d     = 1'b0;
							give       = 1'b1;
						end else begin
							step = 1'b1;
						end
					end
					MODE_MOVING: begin
						if (position_q == wtarget_q) begin
							mode_d = MODE_IDLE;
							give   = 1'b1;
						end else if (position_q < wtarget_q) begin
							step       = 1'b1;
							position_d = position_q + 1'b1;
						end else begin
							step       = 1'b1;
							position_d = position_q - 1'b1;
						end
					end
					MODE_IDLE: begin
						if (home_q) begin
							if (item.slot_free) begin
								mode_d = MODE_HOMING;
								dir_d  = 1'b0;
								take   = 1'b1;
							end
						end else if (position_q != target_q && item.slot_free) begin
							mode_d    = MODE_MOVING;
							wtarget_d = target_q;
							dir_d     = position_q < target_q;
							take      = 1'b1;
						end
					end
					default: mode_d = MODE_IDLE;
				endcase
			end
			default: ; // unused code: no change
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			position_q <= '0;
			target_q   <= '0;
			wtarget_q  <= '0;
			home_q     <= 1'b1;
			dir_q      <= 1'b0;
			shown_q    <= '0;
		end else if (en) begin
			mode_q     <= mode_d;
			position_q <= position_d;
			target_q   <= target_d;
			wtarget_q  <= wtarget_d;
			home_q     <= home_d;
			dir_q      <= dir_d;
			shown_q    <= shown_d;
		end
	end

	assign res.step_pulse    = step;
	assign res.dir_down      = dir_d;
	assign res.take_slot     = take;
	assign res.give_slot     = give;
	assign res.mode_now      = mode_d;
	assign res.shown_percent = shown_d;

	`ASSERT_CLK(a_step_not_idle, clk, arst_n, (en && step) |-> (mode_q != MODE_IDLE))
	`ASSERT_CLK(a_take_leaves_idle, clk, arst_n,
		(en && take) |-> (mode_q == MODE_IDLE && mode_d != MODE_IDLE))
	`ASSERT_CLK(a_home_done, clk, arst_n,
		(en && mode_q == MODE_HOMING && give) |=> (position_q == '0 && !home_q))
	`ASSERT_NEVER(a_pos_range, clk, arst_n, position_q > POS_W'(FULL_TRAVEL_STEPS))
endmodule

>>> rtl/stepper_positioner_with_homing_top.sv
// Step/direction positioner for a stepper-driven blind, with homing.
//
// Input stream (s_axis): one item per transfer. tuser carries the action
// (tick, set target percent, request homing); tdata carries percent, the
// top limit switch level and the drive slot availability.
// Output stream (m_axis): exactly one result per input item, in order:
// step pulse, direction, slot take/give pulses, mode, shown percent.
//
// A result is registered twice on its way out: input register, then result
// register. Throughput: one item per clock while m_axis_tready does not stall
// the pipeline; every item is decided by one pass of compare/increment logic
// and two 101-entry constant tables.
//
// Reset (arst_n low): mode idle, position and target zero, direction up,
// homing pending, both streams empty. The first tick with a free slot
// therefore starts homing.
//
// Stall: while m_axis_tready is low and a result waits, the pipeline holds;
// one more item can still be taken into the input register, then
// s_axis_tready drops. No result is lost or repeated.
module stepper_positioner_with_homing_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] percent, [8] at_top, [9] slot_free, rest 0
	input  logic [1:0]  s_axis_tuser,  // [1:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] step_pulse, [1] dir_down, [2] take_slot, [3] give_slot,
	// [5:4] mode_now, [12:6] shown_percent, rest 0
	output logic [15:0] m_axis_tdata
);
	import spwh_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    adv;
	logic    proc;

	// result register free or being drained this cycle
	assign adv           = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.action    <= s_axis_tuser;
			item_s1.percent   <= s_axis_tdata[7:0];
			item_s1.at_top    <= s_axis_tdata[8];
			item_s1.slot_free <= s_axis_tdata[9];
		end
	end

	// state and per-item decision; state advances only when the result moves on
	spwh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (proc),
		.item   (item_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.shown_percent, res_q.mode_now, res_q.give_slot,
	                        res_q.take_slot, res_q.dir_down, res_q.step_pulse};
endmodule
